### rtl/rgbhsl_pkg.sv
`timescale 1ns / 1ps
// Shared constants, payload types and pipeline stage types of the RGB to HSL converter.
package rgbhsl_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_BITS      = 9 + HUE_FRAC_BITS;
  localparam int CH_FULL       = (1 << CHANNEL_BITS) - 1;
  localparam int HUE_LIMIT     = 360 << HUE_FRAC_BITS;
  localparam int HUE_SCALE     = 60 << HUE_FRAC_BITS;
  localparam int DIV_STEPS     = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;
  localparam int DIV_W         = CHANNEL_BITS + DIV_STEPS;
  localparam int POS_W         = CHANNEL_BITS + 4;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]     hue_angle;
    logic [CHANNEL_BITS-1:0] saturation_level;
    logic [CHANNEL_BITS-1:0] lightness_level;
    logic                    achromatic;
  } hsl_t;

  // max/min stage result; diff is two's complement
  typedef struct packed {
    sector_e                 sector;
    logic [CHANNEL_BITS-1:0] d;
    logic [CHANNEL_BITS:0]   sum;
    logic [CHANNEL_BITS:0]   diff;
  } sel_t;

  // divider stage state: hue and saturation quotients develop side by side
  typedef struct packed {
    logic [DIV_W-1:0]        rem_h;
    logic [DIV_W-1:0]        dv_h;
    logic [DIV_STEPS-1:0]    q_h;
    logic [DIV_W-1:0]        rem_s;
    logic [DIV_W-1:0]        dv_s;
    logic [DIV_STEPS-1:0]    q_s;
    logic [CHANNEL_BITS-1:0] lightness;
    logic                    achromatic;
  } div_t;

endpackage

### rtl/rgbhsl_select.sv
`timescale 1ns / 1ps
// First stage: picks the maximum channel, its sector, range, sum and hue difference.
module rgbhsl_select (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  rgbhsl_pkg::pixel_t  pixel_i,
  output logic                valid_o,
  input  logic                stall_i,
  output rgbhsl_pkg::sel_t    sel_o
);

  logic             valid_q;
  rgbhsl_pkg::sel_t sel_d, sel_q;

  logic [rgbhsl_pkg::CHANNEL_BITS-1:0] mx, mn;

  always_comb begin
    sel_d = '0;
    mx    = '0;
    mn    = '0;
    if (pixel_i.red >= pixel_i.green && pixel_i.red >= pixel_i.blue) begin
      mx           = pixel_i.red;
      mn           = (pixel_i.green < pixel_i.blue) ? pixel_i.green : pixel_i.blue;
      sel_d.sector = rgbhsl_pkg::SECT_RED;
      sel_d.diff   = {1'b0, pixel_i.green} - {1'b0, pixel_i.blue};
    end else if (pixel_i.green >= pixel_i.blue) begin
      mx           = pixel_i.green;
      mn           = (pixel_i.red < pixel_i.blue) ? pixel_i.red : pixel_i.blue;
      sel_d.sector = rgbhsl_pkg::SECT_GREEN;
      sel_d.diff   = {1'b0, pixel_i.blue} - {1'b0, pixel_i.red};
    end else begin
      mx           = pixel_i.blue;
      mn           = (pixel_i.red < pixel_i.green) ? pixel_i.red : pixel_i.green;
      sel_d.sector = rgbhsl_pkg::SECT_BLUE;
      sel_d.diff   = {1'b0, pixel_i.red} - {1'b0, pixel_i.green};
    end
    sel_d.d   = mx - mn;
    sel_d.sum = {1'b0, mx} + {1'b0, mn};
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      sel_q <= sel_d;
    end
  end

  assign valid_o = valid_q;
  assign sel_o   = sel_q;

endmodule

### rtl/rgbhsl_scale.sv
`timescale 1ns / 1ps
// Second stage: hue dividend, saturation dividend and divisors, lightness.
module rgbhsl_scale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  rgbhsl_pkg::sel_t  sel_i,
  output logic              valid_o,
  input  logic              stall_i,
  output rgbhsl_pkg::div_t  div_o
);

  localparam int CB = rgbhsl_pkg::CHANNEL_BITS;
  localparam int PW = rgbhsl_pkg::POS_W;
  localparam int DW = rgbhsl_pkg::DIV_W;
  localparam logic [DW-1:0] HUE_SCALE_W = DW'(rgbhsl_pkg::HUE_SCALE);
  localparam logic [CB:0]   FULL_W      = (CB + 1)'(rgbhsl_pkg::CH_FULL);
  localparam logic [CB:0]   FULL2_W     = (CB + 1)'(2 * rgbhsl_pkg::CH_FULL);

  logic             valid_q;
  rgbhsl_pkg::div_t div_d, div_q;

  logic [PW-1:0] d_w, off_d, diff_x, pos_raw, pos;
  logic [CB:0]   den;
  logic [DW-1:0] d_dw;

  always_comb begin
    d_w = PW'(sel_i.d);
    case (sel_i.sector)
      rgbhsl_pkg::SECT_RED:   off_d = '0;
      rgbhsl_pkg::SECT_GREEN: off_d = d_w << 1;
      rgbhsl_pkg::SECT_BLUE:  off_d = d_w << 2;
      default:                off_d = '0;
    endcase
    diff_x  = {{(PW - CB - 1){sel_i.diff[CB]}}, sel_i.diff};
    pos_raw = off_d + diff_x;
    pos     = pos_raw[PW-1] ? (pos_raw + (d_w << 2) + (d_w << 1)) : pos_raw;
    den     = (sel_i.sum <= FULL_W) ? sel_i.sum : (FULL2_W - sel_i.sum);
    d_dw    = DW'(sel_i.d);

    div_d            = '0;
    div_d.rem_h      = DW'(pos) * HUE_SCALE_W;
    div_d.dv_h       = d_dw << (rgbhsl_pkg::DIV_STEPS - 1);
    div_d.rem_s      = (d_dw << CB) - d_dw;
    div_d.dv_s       = DW'(den) << (rgbhsl_pkg::DIV_STEPS - 1);
    div_d.lightness  = sel_i.sum[CB:1];
    div_d.achromatic = (sel_i.d == '0);
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

### rtl/rgbhsl_div_stage.sv
`timescale 1ns / 1ps
// Divider stage: one restoring quotient bit each for hue and saturation.
module rgbhsl_div_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  rgbhsl_pkg::div_t  div_i,
  output logic              valid_o,
  input  logic              stall_i,
  output rgbhsl_pkg::div_t  div_o
);

  localparam int QW = rgbhsl_pkg::DIV_STEPS;

  logic             valid_q;
  rgbhsl_pkg::div_t div_d, div_q;
  logic             ge_h, ge_s;

  always_comb begin
    ge_h        = (div_i.rem_h >= div_i.dv_h);
    ge_s        = (div_i.rem_s >= div_i.dv_s);
    div_d       = div_i;
    div_d.rem_h = ge_h ? (div_i.rem_h - div_i.dv_h) : div_i.rem_h;
    div_d.rem_s = ge_s ? (div_i.rem_s - div_i.dv_s) : div_i.rem_s;
    div_d.dv_h  = div_i.dv_h >> 1;
    div_d.dv_s  = div_i.dv_s >> 1;
    div_d.q_h   = {div_i.q_h[QW-2:0], ge_h};
    div_d.q_s   = {div_i.q_s[QW-2:0], ge_s};
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

### rtl/rgb_to_hsl_converter.sv
`timescale 1ns / 1ps
// Top level of the pipelined RGB to HSL pixel converter.
// Converts one pixel per clock unless the output stalls, from 8-bit red, green and
// blue to hue in 1/64 degree (0 to 23039), saturation and lightness scaled to 255,
// and an achromatic flag for gray pixels (hue and saturation then read 0). The
// pipeline is a max/min stage, a scaling stage, then a restoring divider that
// settles one quotient bit of hue and of saturation per register stage. Each stage
// holds its item under stall and fills bubbles, so up to 17 items can be in flight
// and input is stalled only once every stage holds a waiting item.
module rgb_to_hsl_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rgbhsl_pkg::pixel_t pixel_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rgbhsl_pkg::hsl_t   hsl_o
);

  localparam int NS = rgbhsl_pkg::DIV_STEPS;
  localparam int CB = rgbhsl_pkg::CHANNEL_BITS;
  localparam int HB = rgbhsl_pkg::HUE_BITS;

  logic             sel_valid, sel_stall;
  rgbhsl_pkg::sel_t sel;

  logic             div_valid [NS+1];
  logic             div_stall [NS+1];
  rgbhsl_pkg::div_t div_chain [NS+1];

  rgbhsl_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .pixel_i (pixel_i),
    .valid_o (sel_valid),
    .stall_i (sel_stall),
    .sel_o   (sel)
  );

  rgbhsl_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sel_valid),
    .stall_o (sel_stall),
    .sel_i   (sel),
    .valid_o (div_valid[0]),
    .stall_i (div_stall[0]),
    .div_o   (div_chain[0])
  );

  for (genvar k = 0; k < NS; k++) begin : g_div
    rgbhsl_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[k]),
      .stall_o (div_stall[k]),
      .div_i   (div_chain[k]),
      .valid_o (div_valid[k+1]),
      .stall_i (div_stall[k+1]),
      .div_o   (div_chain[k+1])
    );
  end

  assign div_stall[NS] = out_stall_i;
  assign out_valid_o   = div_valid[NS];

  // gray pixels divide by zero; force hue and saturation to 0
  always_comb begin
    hsl_o.achromatic       = div_chain[NS].achromatic;
    hsl_o.lightness_level  = div_chain[NS].lightness;
    hsl_o.hue_angle        = div_chain[NS].achromatic ? '0 : div_chain[NS].q_h[HB-1:0];
    hsl_o.saturation_level = div_chain[NS].achromatic ? '0 : div_chain[NS].q_s[CB-1:0];
  end

`ifndef NO_ASSERTIONS
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hsl_o.hue_angle < HB'(rgbhsl_pkg::HUE_LIMIT)))
    else $error("hue beyond 360 degrees");

  a_gray_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hsl_o.achromatic) |->
      (hsl_o.hue_angle == '0 && hsl_o.saturation_level == '0))
    else $error("gray item with non-zero hue or saturation");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && div_valid[0] && sel_valid))
    else $error("input stalled while pipeline has room");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the RGB to HSL converter: directed and random pixels, stalls.
module testbench;
  import rgbhsl_pkg::*;

  localparam int N_DIRECTED   = 17;
  localparam int PHASE_ITEMS  = 645;
  localparam int HOLD_CYCLES  = 80;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SHOWN_FAILS  = 10;

  typedef struct {
    pixel_t px;
    bit     typed;
    hsl_t   hsl;
  } stim_row_t;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_stall_o;
  pixel_t pixel_i     = '0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  hsl_t   hsl_o;

  hsl_t      pending_hsl [$];
  stim_row_t directed_rows [N_DIRECTED];
  int        fail_count    = 0;
  int        cycle_count   = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        hold_off_req  = 1'b0;

  rgb_to_hsl_converter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hsl_o       (hsl_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic hsl_t hsl_of_pixel(pixel_t px);
    int      r, g, b, hi, lo, span, total, slope, pos, den;
    sector_e sector;
    hsl_t    res;
    r = px.red;
    g = px.green;
    b = px.blue;
    if (r >= g && r >= b) begin
      sector = SECT_RED;
      hi     = r;
      lo     = (g < b) ? g : b;
      slope  = g - b;
    end else if (g >= b) begin
      sector = SECT_GREEN;
      hi     = g;
      lo     = (r < b) ? r : b;
      slope  = b - r;
    end else begin
      sector = SECT_BLUE;
      hi     = b;
      lo     = (r < g) ? r : g;
      slope  = r - g;
    end
    span  = hi - lo;
    total = hi + lo;
    res   = '0;
    res.lightness_level = CHANNEL_BITS'(total >> 1);
    res.achromatic      = (span == 0);
    if (span != 0) begin
      // sector offset is two sectors per enum step; red below zero wraps a full turn
      pos = 2 * int'(sector) * span + slope;
      if (pos < 0) pos += 6 * span;
      res.hue_angle = HUE_BITS'((pos * HUE_SCALE) / span);
      den = (total <= CH_FULL) ? total : 2 * CH_FULL - total;
      res.saturation_level = CHANNEL_BITS'((span * CH_FULL) / den);
    end
    return res;
  endfunction

  function automatic stim_row_t make_row(int r, int g, int b, bit typed = 1'b0, int hue = 0,
                                         int sat = 0, int light = 0, bit achro = 1'b0);
    stim_row_t row;
    row.px.red               = CHANNEL_BITS'(r);
    row.px.green             = CHANNEL_BITS'(g);
    row.px.blue              = CHANNEL_BITS'(b);
    row.typed                = typed;
    row.hsl.hue_angle        = HUE_BITS'(hue);
    row.hsl.saturation_level = CHANNEL_BITS'(sat);
    row.hsl.lightness_level  = CHANNEL_BITS'(light);
    row.hsl.achromatic       = achro;
    return row;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    int     v;
    px.red   = CHANNEL_BITS'($urandom);
    px.green = CHANNEL_BITS'($urandom);
    px.blue  = CHANNEL_BITS'($urandom);
    case ($urandom_range(9))
      0: begin
        px.green = px.red;
        px.blue  = px.red;
      end
      1: begin
        case ($urandom_range(2))
          0: px.green = px.red;
          1: px.blue  = px.green;
          default: px.red = px.blue;
        endcase
      end
      2: begin
        px.red   = $urandom_range(1) ? CHANNEL_BITS'(CH_FULL) : '0;
        px.green = $urandom_range(1) ? CHANNEL_BITS'(CH_FULL) : '0;
        v        = $urandom_range(1);
        px.blue  = CHANNEL_BITS'($urandom_range(1) ? CH_FULL - v : v);
      end
      3: begin
        // narrow span: small d stresses the dividers
        v = $urandom_range(CH_FULL - 3);
        px.red   = CHANNEL_BITS'(v + $urandom_range(3));
        px.green = CHANNEL_BITS'(v + $urandom_range(3));
        px.blue  = CHANNEL_BITS'(v + $urandom_range(3));
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic note_failure(string what, hsl_t want, hsl_t got);
    fail_count++;
    if (fail_count <= SHOWN_FAILS)
      $display("%0t %s: expected hue %0d sat %0d light %0d achro %0b, %s",
               $time, what, want.hue_angle, want.saturation_level, want.lightness_level,
               want.achromatic,
               $sformatf("got hue %0d sat %0d light %0d achro %0b",
                         got.hue_angle, got.saturation_level, got.lightness_level,
                         got.achromatic));
  endtask

  task automatic offer_pixel(pixel_t px, bit typed, hsl_t typed_hsl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_hsl.push_back(typed ? typed_hsl : hsl_of_pixel(px));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_hsl.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hsl.size() == 0) begin
        note_failure("item with nothing pending", '0, hsl_o);
      end else if (hsl_o.hue_angle != pending_hsl[0].hue_angle ||
                   hsl_o.saturation_level != pending_hsl[0].saturation_level ||
                   hsl_o.lightness_level != pending_hsl[0].lightness_level ||
                   hsl_o.achromatic != pending_hsl[0].achromatic) begin
        note_failure("mismatch", pending_hsl.pop_front(), hsl_o);
      end else begin
        void'(pending_hsl.pop_front());
      end
    end
  end

  // receiver stalls, with a long hold-off on request
  initial begin
    int hold_left;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) begin
          out_stall_i <= 1'b1;
          @(negedge clk_i);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int phase;
    directed_rows = '{
      make_row(0, 0, 0, 1'b1, 0, 0, 0, 1'b1),
      make_row(255, 255, 255, 1'b1, 0, 0, 255, 1'b1),
      make_row(128, 128, 128, 1'b1, 0, 0, 128, 1'b1),
      make_row(1, 1, 1, 1'b1, 0, 0, 1, 1'b1),
      make_row(255, 0, 0, 1'b1, 0, 255, 127, 1'b0),
      make_row(0, 255, 0, 1'b1, 7680, 255, 127, 1'b0),
      make_row(0, 0, 255, 1'b1, 15360, 255, 127, 1'b0),
      make_row(255, 255, 0),
      make_row(0, 255, 255),
      make_row(255, 0, 255),
      make_row(255, 0, 1),
      make_row(1, 0, 0),
      make_row(0, 0, 1),
      make_row(254, 255, 255),
      make_row(128, 127, 127),
      make_row(170, 85, 0),
      make_row(85, 170, 255)
    };
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      offer_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].hsl);
    drain_results();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // output held off while items keep coming, so the pipe fills and stalls its input
      if (phase != 1) hold_off_req = 1'b1;
      repeat (PHASE_ITEMS) offer_pixel(random_pixel(), 1'b0, '0);
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_hsl.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
